// File: rtl/quadratic_root_solver_core_defines.svh
// Assertion macros shared by the quadratic root solver RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define QRS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error("qrs check failed");

// Consequence that holds in the same cycle as its antecedent.
`define QRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("qrs check failed");

// Consequence that holds in the cycle after its antecedent.
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("qrs check failed");

`endif

// File: rtl/qrs_pkg.sv
// Shared types, constants and the Q16.16 saturation helper of the root solver.
// No dependencies; used by qrs_front and by the top level.
`timescale 1ns / 1ps

package qrs_pkg;

    // Default coefficient width (signed integer, Q16.0).
    localparam int COEF_WIDTH_DEF = 16;

    // Fraction bits of the result format.
    localparam int FRAC_BITS = 16;

    // Width of one result root.
    localparam int ROOT_WIDTH = 32;

    // Classification of one equation.
    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_DEGEN   = 2'd3
    } t_root_kind;

    // Apply a sign to a quotient magnitude and clamp it to signed Q16.16.
    function automatic logic [ROOT_WIDTH-1:0] sat_q16(input logic [63:0] mag,
                                                      input logic neg);
        logic [63:0] neg_val;
        neg_val = ~mag + 64'd1;
        if (neg) begin
            if (mag >= 64'h0000_0000_8000_0000) begin
                return 32'h8000_0000;
            end
            return neg_val[ROOT_WIDTH-1:0];
        end
        if (mag > 64'h0000_0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return mag[ROOT_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/qrs_front.sv
// Front end of the root solver: coefficient products, discriminant and class.
// Depends on qrs_pkg for the kind encoding.
`timescale 1ns / 1ps

module qrs_front #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [COEF_WIDTH-1:0]    i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]    i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]    i_coef_c,
    output logic                            o_valid,
    output qrs_pkg::t_root_kind             o_kind,
    output logic [2*COEF_WIDTH:0]           o_disc,
    output logic signed [COEF_WIDTH+16:0]   o_nb,
    output logic [COEF_WIDTH:0]             o_den,
    output logic                            o_a_neg
);

    localparam int W   = COEF_WIDTH;
    localparam int DSW = 2 * W + 3;
    localparam int NBW = W + 17;

    // Stage one: the two products.
    logic                    r_v1;
    logic signed [W-1:0]     r_a;
    logic signed [W-1:0]     r_b;
    logic signed [2*W-1:0]   r_bb;
    logic signed [2*W-1:0]   r_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= i_coef_a;
            r_b  <= i_coef_b;
            r_bb <= i_coef_b * i_coef_b;
            r_ac <= i_coef_a * i_coef_c;
        end
    end

    // Stage two: discriminant, class, -b scaled to 16 fraction bits, and |2a|.
    logic signed [DSW-1:0] w_disc;
    logic signed [NBW-1:0] w_nb;
    logic signed [W:0]     w_a_ext;
    logic [W:0]            w_a_mag;
    qrs_pkg::t_root_kind   w_kind;

    assign w_disc  = DSW'(r_bb) - (DSW'(r_ac) <<< 2);
    assign w_nb    = -(NBW'(r_b) <<< 16);
    assign w_a_ext = (W+1)'(r_a);
    assign w_a_mag = w_a_ext[W] ? unsigned'(-w_a_ext) : unsigned'(w_a_ext);

    always_comb begin
        if (r_a == '0) begin
            w_kind = qrs_pkg::KIND_DEGEN;
        end else if (w_disc[DSW-1]) begin
            w_kind = qrs_pkg::KIND_COMPLEX;
        end else if (w_disc == '0) begin
            w_kind = qrs_pkg::KIND_DOUBLE;
        end else begin
            w_kind = qrs_pkg::KIND_TWO;
        end
    end

    logic                    r_v2;
    qrs_pkg::t_root_kind     r_kind;
    logic [2*W:0]            r_disc;
    logic signed [NBW-1:0]   r_nb;
    logic [W:0]              r_den;
    logic                    r_a_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind  <= w_kind;
            r_disc  <= w_disc[DSW-1] ? '0 : w_disc[2*W:0];
            r_nb    <= w_nb;
            r_den   <= {w_a_mag[W-1:0], 1'b0};
            r_a_neg <= r_a[W-1];
        end
    end

    assign o_valid = r_v2;
    assign o_kind  = r_kind;
    assign o_disc  = r_disc;
    assign o_nb    = r_nb;
    assign o_den   = r_den;
    assign o_a_neg = r_a_neg;

endmodule

// File: rtl/qrs_sqrt.sv
// Pipelined square root of disc * 2^32, one result bit per register stage.
// No package dependencies; side data rides along with each item.
`timescale 1ns / 1ps

module qrs_sqrt #(
    parameter int DW  = 33,
    parameter int SBW = 1,
    parameter int RW  = (DW + 33) / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [DW-1:0]   i_disc,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);

    localparam int XW = 2 * RW;

    logic              r_valid [1:RW];
    logic [RW-1:0]     r_root  [1:RW];
    logic [RW+1:0]     r_rem   [1:RW];
    logic [SBW-1:0]    r_sb    [1:RW];
    logic [DW-1:0]     r_disc  [1:RW-1];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int IT = RW - 1 - g;

        logic           v_in;
        logic [RW-1:0]  root_in;
        logic [RW+1:0]  rem_in;
        logic [DW-1:0]  d_in;
        logic [SBW-1:0] sb_in;
        logic [XW-1:0]  x_full;
        logic [RW+1:0]  rem_sh;
        logic [RW+1:0]  trial;
        logic           take;

        // Stage sources: module inputs for the first stage, registers after.
        if (g == 0) begin : g_src
            assign v_in    = i_valid;
            assign root_in = '0;
            assign rem_in  = '0;
            assign d_in    = i_disc;
            assign sb_in   = i_sb;
        end else begin : g_src
            assign v_in    = r_valid[g];
            assign root_in = r_root[g];
            assign rem_in  = r_rem[g];
            assign d_in    = r_disc[g];
            assign sb_in   = r_sb[g];
        end

        // One restoring step: bring down the next bit pair and try root*4+1.
        assign x_full = XW'({d_in, 32'b0});
        assign rem_sh = {rem_in[RW-1:0], x_full[2*IT+1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g+1] <= {root_in[RW-2:0], take};
                r_rem[g+1]  <= take ? rem_sh - trial : rem_sh;
                r_sb[g+1]   <= sb_in;
            end
        end

        // The radicand is needed only by the stages that follow.
        if (g < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_disc[g+1] <= d_in;
                end
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_sb    = r_sb[RW];

endmodule

// File: rtl/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// No package dependencies; side data rides along with each item.
`timescale 1ns / 1ps

module qrs_div #(
    parameter int NW   = 35,
    parameter int DENW = 17,
    parameter int SBW  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NW-1:0]    i_num,
    input  logic [DENW-1:0]  i_den,
    input  logic [SBW-1:0]   i_sb,
    output logic             o_valid,
    output logic [NW-1:0]    o_quot,
    output logic [SBW-1:0]   o_sb
);

    localparam int RMW = DENW + 1;

    logic              r_valid [1:NW];
    logic [NW-1:0]     r_quot  [1:NW];
    logic [RMW-1:0]    r_rem   [1:NW];
    logic [SBW-1:0]    r_sb    [1:NW];
    logic [NW-1:0]     r_num   [1:NW-1];
    logic [DENW-1:0]   r_den   [1:NW-1];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic            v_in;
        logic [NW-1:0]   q_in;
        logic [RMW-1:0]  rem_in;
        logic [NW-1:0]   num_in;
        logic [DENW-1:0] den_in;
        logic [SBW-1:0]  sb_in;
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  den_ext;
        logic            take;

        // Stage sources: module inputs for the first stage, registers after.
        if (g == 0) begin : g_src
            assign v_in   = i_valid;
            assign q_in   = '0;
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_src
            assign v_in   = r_valid[g];
            assign q_in   = r_quot[g];
            assign rem_in = r_rem[g];
            assign num_in = r_num[g];
            assign den_in = r_den[g];
            assign sb_in  = r_sb[g];
        end

        // Bring down the next dividend bit and subtract the divisor if it fits.
        assign rem_sh  = {rem_in[DENW-1:0], num_in[NW-1-g]};
        assign den_ext = {1'b0, den_in};
        assign take    = rem_sh >= den_ext;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[g+1] <= {q_in[NW-2:0], take};
                r_rem[g+1]  <= take ? rem_sh - den_ext : rem_sh;
                r_sb[g+1]   <= sb_in;
            end
        end

        // Dividend and divisor are needed only by the stages that follow.
        if (g < NW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[g+1] <= num_in;
                    r_den[g+1] <= den_in;
                end
            end
        end
    end

    assign o_valid = r_valid[NW];
    assign o_quot  = r_quot[NW];
    assign o_sb    = r_sb[NW];

endmodule

// File: rtl/quadratic_root_solver_core.sv
// Quadratic root solver, top level. Uses qrs_pkg, qrs_front, qrs_sqrt, qrs_div.
// Registers in order: the qrs_front stages, RW = (2*COEF_WIDTH + 34) / 2 square-root
// stages, the numerator register, NW divider stages and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears all valid bits, the pipeline starts empty.
`timescale 1ns / 1ps
`include "quadratic_root_solver_core_defines.svh"

module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // coef_a, coef_b, coef_c from bit 0 up, zero padded to whole bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // root_first, root_second from bit 0 up
    output logic [2*qrs_pkg::ROOT_WIDTH-1:0]        m_axis_tdata,
    // root_kind
    output logic [1:0]                              m_axis_tuser
);

    localparam int W     = COEF_WIDTH;
    localparam int DW    = 2 * W + 1;
    localparam int RW    = (DW + 33) / 2;
    localparam int NBW   = W + 17;
    localparam int DENW  = W + 1;
    localparam int NSW   = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
    localparam int SB_SQ = 2 + NBW + DENW + 1;

    // Global advance: the pipeline moves whenever the output register can take.
    logic r_out_valid;
    logic w_adv;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Products, discriminant and class.
    logic                   w_fr_valid;
    qrs_pkg::t_root_kind    w_fr_kind;
    logic [DW-1:0]          w_fr_disc;
    logic signed [NBW-1:0]  w_fr_nb;
    logic [DENW-1:0]        w_fr_den;
    logic                   w_fr_a_neg;

    qrs_front #(
        .COEF_WIDTH (W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (s_axis_tvalid),
        .i_coef_a (s_axis_tdata[W-1:0]),
        .i_coef_b (s_axis_tdata[2*W-1:W]),
        .i_coef_c (s_axis_tdata[3*W-1:2*W]),
        .o_valid  (w_fr_valid),
        .o_kind   (w_fr_kind),
        .o_disc   (w_fr_disc),
        .o_nb     (w_fr_nb),
        .o_den    (w_fr_den),
        .o_a_neg  (w_fr_a_neg)
    );

    // Square root of the discriminant with 16 fraction bits.
    logic              w_sq_valid;
    logic [RW-1:0]     w_sq_root;
    logic [SB_SQ-1:0]  w_sq_sb;

    qrs_sqrt #(
        .DW  (DW),
        .SBW (SB_SQ),
        .RW  (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fr_valid),
        .i_disc  (w_fr_disc),
        .i_sb    ({w_fr_kind, w_fr_nb, w_fr_den, w_fr_a_neg}),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_sb    (w_sq_sb)
    );

    // Numerators -b*2^16 +/- sqrt, split into magnitude and result sign.
    logic [1:0]             w_sq_kind;
    logic signed [NBW-1:0]  w_sq_nb;
    logic [DENW-1:0]        w_sq_den;
    logic                   w_sq_a_neg;
    logic signed [NSW-1:0]  w_s_ext;
    logic signed [NSW-1:0]  w_n1;
    logic signed [NSW-1:0]  w_n2;

    assign {w_sq_kind, w_sq_nb, w_sq_den, w_sq_a_neg} = w_sq_sb;
    assign w_s_ext = NSW'($signed({1'b0, w_sq_root}));
    assign w_n1    = NSW'(w_sq_nb) + w_s_ext;
    assign w_n2    = NSW'(w_sq_nb) - w_s_ext;

    logic              r_nm_valid;
    logic [1:0]        r_nm_kind;
    logic [NSW-1:0]    r_nm_mag1;
    logic [NSW-1:0]    r_nm_mag2;
    logic              r_nm_neg1;
    logic              r_nm_neg2;
    logic [DENW-1:0]   r_nm_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else if (w_adv) begin
            r_nm_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nm_kind <= w_sq_kind;
            r_nm_mag1 <= w_n1[NSW-1] ? unsigned'(-w_n1) : unsigned'(w_n1);
            r_nm_mag2 <= w_n2[NSW-1] ? unsigned'(-w_n2) : unsigned'(w_n2);
            r_nm_neg1 <= w_n1[NSW-1] ^ w_sq_a_neg;
            r_nm_neg2 <= w_n2[NSW-1] ^ w_sq_a_neg;
            r_nm_den  <= w_sq_den;
        end
    end

    // Two divider lanes, one for each root.
    logic              w_div1_valid;
    logic [NSW-1:0]    w_div1_quot;
    logic [2:0]        w_div1_sb;
    logic              w_div2_valid;
    logic [NSW-1:0]    w_div2_quot;
    logic              w_div2_sb;

    qrs_div #(
        .NW   (NSW),
        .DENW (DENW),
        .SBW  (3)
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_nm_valid),
        .i_num   (r_nm_mag1),
        .i_den   (r_nm_den),
        .i_sb    ({r_nm_kind, r_nm_neg1}),
        .o_valid (w_div1_valid),
        .o_quot  (w_div1_quot),
        .o_sb    (w_div1_sb)
    );

    qrs_div #(
        .NW   (NSW),
        .DENW (DENW),
        .SBW  (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_nm_valid),
        .i_num   (r_nm_mag2),
        .i_den   (r_nm_den),
        .i_sb    (r_nm_neg2),
        .o_valid (w_div2_valid),
        .o_quot  (w_div2_quot),
        .o_sb    (w_div2_sb)
    );

    // Saturate and select the root fields by class.
    qrs_pkg::t_root_kind                w_fin_kind;
    logic [qrs_pkg::ROOT_WIDTH-1:0]     w_fin_r1;
    logic [qrs_pkg::ROOT_WIDTH-1:0]     w_fin_r2;

    assign w_fin_kind = qrs_pkg::t_root_kind'(w_div1_sb[2:1]);

    always_comb begin
        w_fin_r1 = '0;
        w_fin_r2 = '0;
        case (w_fin_kind)
            qrs_pkg::KIND_TWO: begin
                w_fin_r1 = qrs_pkg::sat_q16(64'(w_div1_quot), w_div1_sb[0]);
                w_fin_r2 = qrs_pkg::sat_q16(64'(w_div2_quot), w_div2_sb);
            end
            qrs_pkg::KIND_DOUBLE: begin
                w_fin_r1 = qrs_pkg::sat_q16(64'(w_div1_quot), w_div1_sb[0]);
            end
            default: begin
                w_fin_r1 = '0;
                w_fin_r2 = '0;
            end
        endcase
    end

    // Output register.
    qrs_pkg::t_root_kind             r_out_kind;
    logic [qrs_pkg::ROOT_WIDTH-1:0]  r_out_r1;
    logic [qrs_pkg::ROOT_WIDTH-1:0]  r_out_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_div1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_kind <= w_fin_kind;
            r_out_r1   <= w_fin_r1;
            r_out_r2   <= w_fin_r2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r2, r_out_r1};
    assign m_axis_tuser  = r_out_kind;

    // Checks on the pipeline and on the result classes.
    `QRS_ASSERT_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, w_div1_valid == w_div2_valid)
    `QRS_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_adv, $stable(w_div1_valid) && $stable(w_sq_valid))
    `QRS_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, r_out_valid && (r_out_kind == qrs_pkg::KIND_DEGEN), (r_out_r1 == '0) && (r_out_r2 == '0))
    `QRS_ASSERT_IMPLY(a_second_only_two, i_clk, i_rst_n, r_out_valid && (r_out_kind != qrs_pkg::KIND_TWO), r_out_r2 == '0)

endmodule
